### sv/sdpm_pkg.sv
// Shared types and codes for the sparse dot product merge unit.
package sdpm_pkg;

  // Operation codes carried in the mode field of an input word
  localparam logic [1:0] MODE_APPEND_A = 2'd0;
  localparam logic [1:0] MODE_APPEND_B = 2'd1;
  localparam logic [1:0] MODE_COMPUTE  = 2'd2;

  // Field widths fixed by the interface
  localparam int unsigned IN_INDEX_W = 16;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned ACC_W      = 64;
  localparam int unsigned MATCH_W    = 9;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic append_a;  // write the input word into store A
    logic append_b;  // write the input word into store B
    logic init;      // clear heads and accumulator for a new merge
    logic rd;        // read both heads
    logic cmp;       // compare heads, multiply on a match, advance
    logic finish;    // empty both stores and the drop flag
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic more;      // both heads still inside their stores
  } status_t;

endpackage

### sv/sdpm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module sdpm_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Register the read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/sdpm_datapath.sv
// Datapath: both stores, fill counts, merge heads, multiplier and saturating accumulator.
module sdpm_datapath #(
  parameter int unsigned DEPTH      = 256,
  parameter int unsigned INDEX_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  sdpm_pkg::cmd_t                       cmd_i,
  output sdpm_pkg::status_t                    status_o,
  input  logic [sdpm_pkg::IN_INDEX_W-1:0]      index_i,
  input  logic signed [sdpm_pkg::VALUE_W-1:0]  value_i,
  output logic signed [sdpm_pkg::ACC_W-1:0]    dot_product_o,
  output logic [sdpm_pkg::MATCH_W-1:0]         match_count_o,
  output logic                                 saturated_o,
  output logic                                 dropped_o
);

  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned VW    = sdpm_pkg::VALUE_W;
  localparam int unsigned AccW  = sdpm_pkg::ACC_W;
  localparam int unsigned EW    = INDEX_BITS + VW;
  localparam int unsigned ExtW  = (INDEX_BITS > sdpm_pkg::IN_INDEX_W) ?
                                  INDEX_BITS : sdpm_pkg::IN_INDEX_W;

  logic [CW-1:0]    count_a_q, count_a_d;
  logic [CW-1:0]    count_b_q, count_b_d;
  logic             ovf_q, ovf_d;
  logic [CW-1:0]    head_a_q, head_a_d;
  logic [CW-1:0]    head_b_q, head_b_d;
  logic             prod_vld_q, prod_vld_d;
  logic signed [AccW-1:0] prod_q, prod_d;
  logic signed [AccW-1:0] acc_q, acc_d;
  logic             clip_q, clip_d;
  logic [sdpm_pkg::MATCH_W-1:0] match_q, match_d;

  logic [ExtW-1:0]       index_ext;
  logic [EW-1:0]         wdata;
  logic                  full_a, full_b;
  logic                  we_a, we_b;
  logic [EW-1:0]         rdata_a, rdata_b;
  logic [INDEX_BITS-1:0] idx_a, idx_b;
  logic signed [VW-1:0]  val_a, val_b;
  logic signed [AccW-1:0] sum;
  logic                  sum_ovf;

  // Fit the input index to the stored width, dropping high bits or zero-extending
  assign index_ext = ExtW'(index_i);
  assign wdata     = {index_ext[INDEX_BITS-1:0], value_i};

  assign full_a = (count_a_q == CW'(DEPTH));
  assign full_b = (count_b_q == CW'(DEPTH));
  assign we_a   = cmd_i.append_a && !full_a;
  assign we_b   = cmd_i.append_b && !full_b;

  sdpm_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_store_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (count_a_q[AW-1:0]),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (head_a_q[AW-1:0]),
    .rdata_o (rdata_a)
  );

  sdpm_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_store_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (count_b_q[AW-1:0]),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (head_b_q[AW-1:0]),
    .rdata_o (rdata_b)
  );

  assign idx_a = rdata_a[EW-1:VW];
  assign idx_b = rdata_b[EW-1:VW];
  assign val_a = rdata_a[VW-1:0];
  assign val_b = rdata_b[VW-1:0];

  assign status_o.more = (head_a_q < count_a_q) && (head_b_q < count_b_q);

  // Add the registered product, clip to the nearer limit on overflow
  assign sum     = acc_q + prod_q;
  assign sum_ovf = (acc_q[AccW-1] == prod_q[AccW-1]) && (sum[AccW-1] != acc_q[AccW-1]);

  // Fill counts and drop flag
  always_comb begin
    count_a_d = count_a_q;
    count_b_d = count_b_q;
    ovf_d     = ovf_q;
    if (we_a) begin
      count_a_d = count_a_q + CW'(1);
    end
    if (we_b) begin
      count_b_d = count_b_q + CW'(1);
    end
    if ((cmd_i.append_a && full_a) || (cmd_i.append_b && full_b)) begin
      ovf_d = 1'b1;
    end
    if (cmd_i.finish) begin
      count_a_d = '0;
      count_b_d = '0;
      ovf_d     = 1'b0;
    end
  end

  // Merge step: compare heads, form the product, advance
  always_comb begin
    head_a_d   = head_a_q;
    head_b_d   = head_b_q;
    prod_vld_d = 1'b0;
    prod_d     = prod_q;
    match_d    = match_q;
    if (cmd_i.init) begin
      head_a_d = '0;
      head_b_d = '0;
      match_d  = '0;
    end else if (cmd_i.cmp) begin
      priority if (idx_a == idx_b) begin
        prod_d     = val_a * val_b;
        prod_vld_d = 1'b1;
        match_d    = match_q + sdpm_pkg::MATCH_W'(1);
        head_a_d   = head_a_q + CW'(1);
        head_b_d   = head_b_q + CW'(1);
      end else if (idx_a < idx_b) begin
        head_a_d = head_a_q + CW'(1);
      end else begin
        head_b_d = head_b_q + CW'(1);
      end
    end
  end

  // Accumulate the product in the cycle after it is registered
  always_comb begin
    acc_d  = acc_q;
    clip_d = clip_q;
    if (cmd_i.init) begin
      acc_d  = '0;
      clip_d = 1'b0;
    end else if (prod_vld_q) begin
      if (sum_ovf) begin
        acc_d  = acc_q[AccW-1] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
        clip_d = 1'b1;
      end else begin
        acc_d = sum;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_a_q  <= '0;
      count_b_q  <= '0;
      ovf_q      <= 1'b0;
      head_a_q   <= '0;
      head_b_q   <= '0;
      prod_vld_q <= 1'b0;
    end else begin
      count_a_q  <= count_a_d;
      count_b_q  <= count_b_d;
      ovf_q      <= ovf_d;
      head_a_q   <= head_a_d;
      head_b_q   <= head_b_d;
      prod_vld_q <= prod_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    acc_q   <= acc_d;
    clip_q  <= clip_d;
    match_q <= match_d;
  end

  assign dot_product_o = acc_q;
  assign match_count_o = match_q;
  assign saturated_o   = clip_q;
  assign dropped_o     = ovf_q;

endmodule

### sv/sdpm_ctrl.sv
// Controller: sequences appends, the merge step (read state, then compare state) and the result word.
module sdpm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [1:0]        mode_i,
  input  sdpm_pkg::status_t status_i,
  output sdpm_pkg::cmd_t    cmd_o,
  output logic              busy_o,
  output logic              done_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RD   = 4'b0010,
    ST_CMP  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          priority if (mode_i == sdpm_pkg::MODE_APPEND_A) begin
            cmd_o.append_a = 1'b1;
          end else if (mode_i == sdpm_pkg::MODE_APPEND_B) begin
            cmd_o.append_b = 1'b1;
          end else if (mode_i == sdpm_pkg::MODE_COMPUTE) begin
            cmd_o.init = 1'b1;
            state_d    = ST_RD;
          end else begin
            // unused mode: drop the word
            state_d = ST_IDLE;
          end
        end
      end
      ST_RD: begin
        if (status_i.more) begin
          cmd_o.rd = 1'b1;
          state_d  = ST_CMP;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = ST_RD;
      end
      ST_DONE: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_DONE);

endmodule

### sv/sparse_dot_product_merge_unit.sv
// Top level of the sparse dot product merge unit.
//
//   channel   handshake              payload
//   -------   --------------------   ---------------------------------------------
//   command   start_i, busy_o        mode_i, index_i, value_i
//   result    done_o (strobe)        dot_product_o, match_count_o, saturated_o,
//                                    dropped_o
//
// An append word leaves busy_o low, so appends go back to back.
// A compute word clears the result, then runs S merge steps (at most
// count_a + count_b - 1): each step reads both heads through the registered read
// port of each store and then compares them. done_o is high in the last cycle.
// Reset clears the counts, the drop flag and the controller; stores need no clear.
// done_o is high for a single cycle and cannot be stalled; dropped_o clears after it.
module sparse_dot_product_merge_unit #(
  parameter int unsigned DEPTH      = 256,
  parameter int unsigned INDEX_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic [1:0]                           mode_i,
  input  logic [sdpm_pkg::IN_INDEX_W-1:0]      index_i,
  input  logic signed [sdpm_pkg::VALUE_W-1:0]  value_i,
  output logic                                 done_o,
  output logic signed [sdpm_pkg::ACC_W-1:0]    dot_product_o,
  output logic [sdpm_pkg::MATCH_W-1:0]         match_count_o,
  output logic                                 saturated_o,
  output logic                                 dropped_o
);

  sdpm_pkg::cmd_t    cmd;
  sdpm_pkg::status_t status;

  sdpm_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .mode_i   (mode_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  sdpm_datapath #(
    .DEPTH      (DEPTH),
    .INDEX_BITS (INDEX_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .index_i       (index_i),
    .value_i       (value_i),
    .dot_product_o (dot_product_o),
    .match_count_o (match_count_o),
    .saturated_o   (saturated_o),
    .dropped_o     (dropped_o)
  );

endmodule
